// ===== src/per_stream_resequencer_macros.svh =====
// Assertion macros shared by the resequencer modules.
`ifndef PER_STREAM_RESEQUENCER_MACROS_SVH
`define PER_STREAM_RESEQUENCER_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define RSQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define RSQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition must never be seen.
`define RSQ_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== src/rsq_pkg.sv =====
// Shared constants, codes and the result type of the per-stream resequencer.
package rsq_pkg;

    // Default configuration of the block.
    localparam int STREAMS_DEF      = 4;
    localparam int WINDOW_DEF       = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Fixed field widths of the ports.
    localparam int STREAM_W = 2;
    localparam int SEQ_W    = 32;
    localparam int OUT_W    = 32;

    // Kind of a result.
    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Status codes of an arriving message.
    localparam logic [1:0] STAT_DUP       = 2'd0;
    localparam logic [1:0] STAT_IN_ORDER  = 2'd1;
    localparam logic [1:0] STAT_OUT_ORDER = 2'd2;
    localparam logic [1:0] STAT_BEYOND    = 2'd3;
    // Status field carried by a released message.
    localparam logic [1:0] STAT_RELEASE   = 2'd0;

    // One result item as it travels from the sequencer to the output register.
    typedef struct packed {
        logic                kind;
        logic [1:0]          status;
        logic [STREAM_W-1:0] stream;
        logic [SEQ_W-1:0]    seq;
        logic [OUT_W-1:0]    payload;
        logic                last;
    } t_result;

endpackage

// ===== src/rsq_state_mem.sv =====
// Per-stream state memory: next-expected sequence number and its slot position.
module rsq_state_mem
    import rsq_pkg::*;
#(
    parameter int STREAMS = STREAMS_DEF,
    parameter int WINDOW  = WINDOW_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_rd_en,
    input  logic [((STREAMS > 1) ? $clog2(STREAMS) : 1)-1:0] i_rd_addr,
    output logic [SEQ_W-1:0]                            o_rd_ne,
    output logic [$clog2(WINDOW)-1:0]                   o_rd_head,
    input  logic                                        i_wr_en,
    input  logic [((STREAMS > 1) ? $clog2(STREAMS) : 1)-1:0] i_wr_addr,
    input  logic [SEQ_W-1:0]                            i_wr_ne,
    input  logic [$clog2(WINDOW)-1:0]                   i_wr_head
);

    localparam int SW = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int HW = $clog2(WINDOW);

    logic [SEQ_W-1:0]   mem_ne   [STREAMS];
    logic [HW-1:0]      mem_head [STREAMS];
    logic [STREAMS-1:0] r_written;
    logic [SEQ_W-1:0]   r_rd_ne;
    logic [HW-1:0]      r_rd_head;

    // An entry that was never written reads as the reset state: sequence one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr_en) begin
            r_written[i_wr_addr] <= 1'b1;
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_ne[i_wr_addr]   <= i_wr_ne;
            mem_head[i_wr_addr] <= i_wr_head;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_ne   <= r_written[i_rd_addr] ? mem_ne[i_rd_addr]   : SEQ_W'(1);
            r_rd_head <= r_written[i_rd_addr] ? mem_head[i_rd_addr] : HW'(1);
        end
    end

    assign o_rd_ne   = r_rd_ne;
    assign o_rd_head = r_rd_head;

endmodule

// ===== src/rsq_slot_mem.sv =====
// Slot memory: one valid bit and one payload word per stream and window slot.
`include "per_stream_resequencer_macros.svh"

module rsq_slot_mem
    import rsq_pkg::*;
#(
    parameter int STREAMS      = STREAMS_DEF,
    parameter int WINDOW       = WINDOW_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    output logic o_busy,
    input  logic i_wr_en,
    input  logic [((STREAMS > 1) ? $clog2(STREAMS) : 1) + $clog2(WINDOW)-1:0] i_wr_addr,
    input  logic i_wr_valid,
    input  logic [((PAYLOAD_BITS < OUT_W) ? PAYLOAD_BITS : OUT_W)-1:0] i_wr_data,
    input  logic i_rd_en,
    input  logic [((STREAMS > 1) ? $clog2(STREAMS) : 1) + $clog2(WINDOW)-1:0] i_rd_addr,
    output logic o_rd_valid,
    output logic [((PAYLOAD_BITS < OUT_W) ? PAYLOAD_BITS : OUT_W)-1:0] o_rd_data
);

    localparam int SW    = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int HW    = $clog2(WINDOW);
    localparam int AW    = SW + HW;
    localparam int PW    = (PAYLOAD_BITS < OUT_W) ? PAYLOAD_BITS : OUT_W;
    localparam int DEPTH = STREAMS << HW;

    logic [PW:0]   mem [DEPTH];
    logic          r_busy;
    logic [AW-1:0] r_clr_addr;
    logic [PW:0]   r_rd_word;

    // Clearing pass after reset: one entry a cycle through the whole memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Single write port, shared between the clearing pass and the sequencer.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= {i_wr_valid, i_wr_data};
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_word <= mem[i_rd_addr];
        end
    end

    assign o_busy     = r_busy;
    assign o_rd_valid = r_rd_word[PW];
    assign o_rd_data  = r_rd_word[PW-1:0];

    // The sequencer must leave the memory alone while it is being cleared.
    `RSQ_ASSERT_NEVER(a_no_access_in_clear, r_busy && (i_wr_en || i_rd_en), "slot access during clearing pass")

endmodule

// ===== src/rsq_ctrl.sv =====
// Sequencer: classifies each message, stores it and drains the in-order run.
`include "per_stream_resequencer_macros.svh"

module rsq_ctrl
    import rsq_pkg::*;
#(
    parameter int STREAMS      = STREAMS_DEF,
    parameter int WINDOW       = WINDOW_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input channel.
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [STREAM_W-1:0]   i_stream_index,
    input  logic [SEQ_W-1:0]      i_seq_number,
    input  logic [OUT_W-1:0]      i_payload,
    // Stream state memory.
    output logic                  o_st_rd_en,
    output logic [((STREAMS > 1) ? $clog2(STREAMS) : 1)-1:0] o_st_rd_addr,
    input  logic [SEQ_W-1:0]      i_st_ne,
    input  logic [$clog2(WINDOW)-1:0] i_st_head,
    output logic                  o_st_wr_en,
    output logic [((STREAMS > 1) ? $clog2(STREAMS) : 1)-1:0] o_st_wr_addr,
    output logic [SEQ_W-1:0]      o_st_wr_ne,
    output logic [$clog2(WINDOW)-1:0] o_st_wr_head,
    // Slot memory.
    input  logic                  i_slot_busy,
    output logic                  o_slot_wr_en,
    output logic [((STREAMS > 1) ? $clog2(STREAMS) : 1) + $clog2(WINDOW)-1:0] o_slot_wr_addr,
    output logic                  o_slot_wr_valid,
    output logic [((PAYLOAD_BITS < OUT_W) ? PAYLOAD_BITS : OUT_W)-1:0] o_slot_wr_data,
    output logic                  o_slot_rd_en,
    output logic [((STREAMS > 1) ? $clog2(STREAMS) : 1) + $clog2(WINDOW)-1:0] o_slot_rd_addr,
    input  logic                  i_slot_rd_valid,
    input  logic [((PAYLOAD_BITS < OUT_W) ? PAYLOAD_BITS : OUT_W)-1:0] i_slot_rd_data,
    // Result towards the output register.
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output t_result               o_res
);

    localparam int SW = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int HW = $clog2(WINDOW);
    localparam int PW = (PAYLOAD_BITS < OUT_W) ? PAYLOAD_BITS : OUT_W;
    localparam logic [HW:0] WIN = (HW + 1)'(WINDOW);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLASS  = 3'd1;
    localparam logic [2:0] S_RDHEAD = 3'd2;
    localparam logic [2:0] S_CHK    = 3'd3;
    localparam logic [2:0] S_FINAL  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [STREAM_W-1:0] r_stream, n_stream;
    logic [SEQ_W-1:0]    r_seq, n_seq;
    logic [PW-1:0]       r_pay, n_pay;
    logic [SEQ_W-1:0]    r_ne, n_ne;
    logic [HW-1:0]       r_head, n_head;
    t_result             r_pend, n_pend;

    logic                accept;
    logic                in_range;
    logic [SW-1:0]       stream_a;
    logic [SEQ_W-1:0]    diff;
    logic                is_dup;
    logic                is_beyond;
    logic [HW:0]         slot_sum;
    logic [HW-1:0]       slot;
    logic [HW-1:0]       head_inc;

    assign accept   = i_in_valid && !o_in_stall;
    assign in_range = 32'(r_stream) < STREAMS;
    assign stream_a = SW'(r_stream);

    // Window check against the freshly read next-expected number.
    assign diff      = r_seq - i_st_ne;
    assign is_dup    = r_seq < i_st_ne;
    assign is_beyond = !is_dup && (diff >= SEQ_W'(WINDOW));

    // Slot of the arriving message: head position plus its offset, wrapped once.
    assign slot_sum = {1'b0, i_st_head} + {1'b0, diff[HW-1:0]};
    assign slot     = (slot_sum >= WIN) ? HW'(slot_sum - WIN) : slot_sum[HW-1:0];

    // Head position follows next-expected modulo the window, also across the
    // wrap of the sequence space.
    assign head_inc = (r_ne == '1) ? '0 :
                      (r_head == HW'(WINDOW - 1)) ? '0 : r_head + 1'b1;

    // State memory read is issued on the transfer itself.
    assign o_in_stall   = (r_state != S_IDLE) || i_slot_busy;
    assign o_st_rd_en   = accept && (32'(i_stream_index) < STREAMS);
    assign o_st_rd_addr = SW'(i_stream_index);

    // Slot reads happen only in their own state, so a slot write never
    // overlaps a read of the same entry.
    assign o_slot_rd_en   = (r_state == S_RDHEAD);
    assign o_slot_rd_addr = {stream_a, r_head};

    // Next-state and datapath logic.
    always_comb begin
        n_state  = r_state;
        n_stream = r_stream;
        n_seq    = r_seq;
        n_pay    = r_pay;
        n_ne     = r_ne;
        n_head   = r_head;
        n_pend   = r_pend;

        o_st_wr_en      = 1'b0;
        o_st_wr_addr    = stream_a;
        o_st_wr_ne      = r_ne;
        o_st_wr_head    = r_head;
        o_slot_wr_en    = 1'b0;
        o_slot_wr_addr  = {stream_a, r_head};
        o_slot_wr_valid = 1'b0;
        o_slot_wr_data  = r_pay;
        o_res_valid     = 1'b0;
        o_res           = r_pend;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_stream = i_stream_index;
                    n_seq    = i_seq_number;
                    n_pay    = PW'(i_payload);
                    n_state  = S_CLASS;
                end
            end
            S_CLASS: begin
                n_pend.kind    = KIND_STATUS;
                n_pend.stream  = r_stream;
                n_pend.seq     = r_seq;
                n_pend.payload = '0;
                n_pend.last    = 1'b0;
                if (!in_range) begin
                    n_pend.status = STAT_BEYOND;
                    n_state       = S_FINAL;
                end else begin
                    n_ne   = i_st_ne;
                    n_head = i_st_head;
                    if (is_dup) begin
                        n_pend.status = STAT_DUP;
                    end else if (is_beyond) begin
                        n_pend.status = STAT_BEYOND;
                    end else begin
                        n_pend.status   = (r_seq == i_st_ne) ? STAT_IN_ORDER : STAT_OUT_ORDER;
                        o_slot_wr_en    = 1'b1;
                        o_slot_wr_addr  = {stream_a, slot};
                        o_slot_wr_valid = 1'b1;
                    end
                    n_state = S_RDHEAD;
                end
            end
            S_RDHEAD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                // The pending result is last unless the head slot is filled.
                o_res_valid = 1'b1;
                o_res.last  = !i_slot_rd_valid;
                if (i_res_ready) begin
                    if (i_slot_rd_valid) begin
                        n_pend.kind     = KIND_RELEASE;
                        n_pend.status   = STAT_RELEASE;
                        n_pend.stream   = r_stream;
                        n_pend.seq      = r_ne;
                        n_pend.payload  = OUT_W'(i_slot_rd_data);
                        n_pend.last     = 1'b0;
                        o_slot_wr_en    = 1'b1;
                        o_slot_wr_valid = 1'b0;
                        n_ne            = r_ne + 1'b1;
                        n_head          = head_inc;
                        n_state         = S_RDHEAD;
                    end else begin
                        o_st_wr_en = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            S_FINAL: begin
                o_res_valid = 1'b1;
                o_res.last  = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers of the current message.
    always_ff @(posedge i_clk) begin
        r_stream <= n_stream;
        r_seq    <= n_seq;
        r_pay    <= n_pay;
        r_ne     <= n_ne;
        r_head   <= n_head;
        r_pend   <= n_pend;
    end

    `RSQ_ASSERT_NEVER(a_slot_rw_overlap, o_slot_wr_en && o_slot_rd_en, "slot read and write in one cycle")
    `RSQ_ASSERT_NEXT(a_last_ends_item, o_res_valid && i_res_ready && o_res.last, r_state == S_IDLE, "sequencer busy after final result")
    `RSQ_ASSERT_NEXT(a_ne_steps_by_one, (r_state == S_CHK) && i_res_ready && i_slot_rd_valid, r_ne == SEQ_W'($past(r_ne) + 1'b1), "next-expected did not advance by one on release")

endmodule

// ===== src/per_stream_resequencer.sv =====
// Top level of the per-stream resequencer: memories, sequencer and output register.
//
//  Channel   Handshake                      Fields
//  --------  -----------------------------  ---------------------------------------------
//  input     i_in_valid / o_in_stall        i_stream_index, i_seq_number, i_payload
//  output    o_out_valid / i_out_stall      o_kind, o_status, o_out_stream, o_out_seq,
//                                           o_out_payload, o_last
//
// An item walks the sequencer through classification, a read of the head slot and a check;
// each released message repeats the read and the check, and the check also clears the slot,
// since the single slot memory port has a registered read. An item on a stream index
// outside the configured range goes from classification straight to its final result.
// After reset the slot memory is cleared, one entry a cycle, through all STREAMS * 2^ceil(log2
// WINDOW) entries (64 by default); o_in_stall stays high until this pass is done.
// A stalled output holds the sequencer in its emit state; the next item is accepted while
// the final result of the previous one still waits in the output register.
module per_stream_resequencer
    import rsq_pkg::*;
#(
    parameter int STREAMS      = STREAMS_DEF,
    parameter int WINDOW       = WINDOW_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [STREAM_W-1:0] i_stream_index,
    input  logic [SEQ_W-1:0]    i_seq_number,
    input  logic [OUT_W-1:0]    i_payload,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_kind,
    output logic [1:0]          o_status,
    output logic [STREAM_W-1:0] o_out_stream,
    output logic [SEQ_W-1:0]    o_out_seq,
    output logic [OUT_W-1:0]    o_out_payload,
    output logic                o_last
);

    localparam int SW = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int HW = $clog2(WINDOW);
    localparam int PW = (PAYLOAD_BITS < OUT_W) ? PAYLOAD_BITS : OUT_W;

    logic            st_rd_en;
    logic [SW-1:0]   st_rd_addr;
    logic [SEQ_W-1:0] st_rd_ne;
    logic [HW-1:0]   st_rd_head;
    logic            st_wr_en;
    logic [SW-1:0]   st_wr_addr;
    logic [SEQ_W-1:0] st_wr_ne;
    logic [HW-1:0]   st_wr_head;

    logic             slot_busy;
    logic             slot_wr_en;
    logic [SW+HW-1:0] slot_wr_addr;
    logic             slot_wr_valid;
    logic [PW-1:0]    slot_wr_data;
    logic             slot_rd_en;
    logic [SW+HW-1:0] slot_rd_addr;
    logic             slot_rd_valid;
    logic [PW-1:0]    slot_rd_data;

    logic    res_valid;
    logic    res_ready;
    t_result res;

    logic    r_out_valid;
    t_result r_out;

    rsq_state_mem #(
        .STREAMS (STREAMS),
        .WINDOW  (WINDOW)
    ) u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (st_rd_addr),
        .o_rd_ne   (st_rd_ne),
        .o_rd_head (st_rd_head),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_ne   (st_wr_ne),
        .i_wr_head (st_wr_head)
    );

    rsq_slot_mem #(
        .STREAMS      (STREAMS),
        .WINDOW       (WINDOW),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_slot_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .o_busy     (slot_busy),
        .i_wr_en    (slot_wr_en),
        .i_wr_addr  (slot_wr_addr),
        .i_wr_valid (slot_wr_valid),
        .i_wr_data  (slot_wr_data),
        .i_rd_en    (slot_rd_en),
        .i_rd_addr  (slot_rd_addr),
        .o_rd_valid (slot_rd_valid),
        .o_rd_data  (slot_rd_data)
    );

    rsq_ctrl #(
        .STREAMS      (STREAMS),
        .WINDOW       (WINDOW),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_stream_index  (i_stream_index),
        .i_seq_number    (i_seq_number),
        .i_payload       (i_payload),
        .o_st_rd_en      (st_rd_en),
        .o_st_rd_addr    (st_rd_addr),
        .i_st_ne         (st_rd_ne),
        .i_st_head       (st_rd_head),
        .o_st_wr_en      (st_wr_en),
        .o_st_wr_addr    (st_wr_addr),
        .o_st_wr_ne      (st_wr_ne),
        .o_st_wr_head    (st_wr_head),
        .i_slot_busy     (slot_busy),
        .o_slot_wr_en    (slot_wr_en),
        .o_slot_wr_addr  (slot_wr_addr),
        .o_slot_wr_valid (slot_wr_valid),
        .o_slot_wr_data  (slot_wr_data),
        .o_slot_rd_en    (slot_rd_en),
        .o_slot_rd_addr  (slot_rd_addr),
        .i_slot_rd_valid (slot_rd_valid),
        .i_slot_rd_data  (slot_rd_data),
        .o_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .o_res           (res)
    );

    // Output register: takes a new result when empty or when its transfer completes.
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_status      = r_out.status;
    assign o_out_stream  = r_out.stream;
    assign o_out_seq     = r_out.seq;
    assign o_out_payload = r_out.payload;
    assign o_last        = r_out.last;

endmodule

// ===== tb/sv/resequencer_order_checker.sv =====
// Order checker for the per-stream resequencer: predicts every result and compares transfers.
module resequencer_order_checker
    import rsq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [STREAM_W-1:0] i_stream_index,
    input  logic [SEQ_W-1:0]    i_seq_number,
    input  logic [OUT_W-1:0]    i_payload,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic                i_kind,
    input  logic [1:0]          i_status,
    input  logic [STREAM_W-1:0] i_out_stream,
    input  logic [SEQ_W-1:0]    i_out_seq,
    input  logic [OUT_W-1:0]    i_out_payload,
    input  logic                i_last,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_checked
);

    localparam int STREAMS     = STREAMS_DEF;
    localparam int WINDOW      = WINDOW_DEF;

    // Predicted state: next sequence number per stream and the buffered slots.
    logic [SEQ_W-1:0] next_seq  [STREAMS];
    logic             held      [STREAMS][WINDOW];
    logic [OUT_W-1:0] held_word [STREAMS][WINDOW];
    t_result          expected_results [$];
    int               mismatches = 0;
    int               matched    = 0;

    // Applies one arriving message to the predicted state and queues the results it causes.
    task automatic predict_arrival(input logic [STREAM_W-1:0] strm,
                                   input logic [SEQ_W-1:0]    seq,
                                   input logic [OUT_W-1:0]    word);
        logic [SEQ_W-1:0] want_seq;
        logic [SEQ_W-1:0] ahead;
        logic [1:0]       stat;
        int               slot;
        int               n;
        t_result          item;
        want_seq = next_seq[strm];
        ahead    = seq - want_seq;
        if (seq < want_seq) begin
            stat = STAT_DUP;
        end else if (ahead >= SEQ_W'(WINDOW)) begin
            stat = STAT_BEYOND;
        end else begin
            slot = int'(seq % SEQ_W'(WINDOW));
            held[strm][slot]      = 1'b1;
            held_word[strm][slot] = word;
            stat = (seq == want_seq) ? STAT_IN_ORDER : STAT_OUT_ORDER;
        end
        item = '{kind: KIND_STATUS, status: stat, stream: strm,
                 seq: seq, payload: '0, last: 1'b0};
        expected_results.insert(expected_results.size(), item);
        // Release the consecutive run of buffered messages, oldest first.
        for (n = 0; n < WINDOW; n++) begin
            slot = int'(want_seq % SEQ_W'(WINDOW));
            if (!held[strm][slot]) break;
            item = '{kind: KIND_RELEASE, status: STAT_RELEASE,
                     stream: strm, seq: want_seq,
                     payload: held_word[strm][slot], last: 1'b0};
            expected_results.insert(expected_results.size(), item);
            held[strm][slot] = 1'b0;
            want_seq = want_seq + 1'b1;
        end
        next_seq[strm] = want_seq;
        expected_results[expected_results.size() - 1].last = 1'b1;
    endtask

    // Reports one field that differs from its prediction.
    task automatic compare_field(input string            field_name,
                                 input logic [OUT_W-1:0] want,
                                 input logic [OUT_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field_name, want, got);
        end
    endtask

    // Watch both channels at every rising edge.
    always @(posedge i_clk) begin : watch
        t_result want;
        int      s;
        int      w;
        if (!i_rst_n) begin
            for (s = 0; s < STREAMS; s++) begin
                next_seq[s] = SEQ_W'(1);
                for (w = 0; w < WINDOW; w++) begin
                    held[s][w]      = 1'b0;
                    held_word[s][w] = '0;
                end
            end
            expected_results.delete();
        end else begin
            // A result transfer is compared with the oldest expectation.
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual seq %0h kind %0h",
                             $time, i_out_seq, i_kind);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("kind",    OUT_W'(want.kind),    OUT_W'(i_kind));
                    compare_field("status",  OUT_W'(want.status),  OUT_W'(i_status));
                    compare_field("stream",  OUT_W'(want.stream),  OUT_W'(i_out_stream));
                    compare_field("seq",     OUT_W'(want.seq),     OUT_W'(i_out_seq));
                    compare_field("payload", OUT_W'(want.payload), OUT_W'(i_out_payload));
                    compare_field("last",    OUT_W'(want.last),    OUT_W'(i_last));
                    matched++;
                end
            end
            // An input transfer adds its predicted results.
            if (i_in_valid && !i_in_stall)
                predict_arrival(i_stream_index, i_seq_number, i_payload);
        end
        o_errors  <= mismatches;
        o_pending <= expected_results.size();
        o_checked <= matched;
    end

endmodule

// ===== tb/sv/per_stream_resequencer_test.sv =====
// Testbench top for the per-stream resequencer: drives messages and gives the verdict.
module per_stream_resequencer_test;
    import rsq_pkg::*;

    localparam int STREAMS         = STREAMS_DEF;
    localparam int WINDOW          = WINDOW_DEF;
    localparam int RANDOM_MESSAGES = 300;
    // Settling time covers the longest drain, a full window of releases, with a margin on top.
    localparam int SETTLE_CYCLES   = 2 * WINDOW_DEF + 12;
    localparam int LIMIT_CYCLES    = 400000;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic [STREAM_W-1:0] i_stream_index = '0;
    logic [SEQ_W-1:0]    i_seq_number   = '0;
    logic [OUT_W-1:0]    i_payload      = '0;
    logic                i_out_stall    = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic                o_kind;
    logic [1:0]          o_status;
    logic [STREAM_W-1:0] o_out_stream;
    logic [SEQ_W-1:0]    o_out_seq;
    logic [OUT_W-1:0]    o_out_payload;
    logic                o_last;
    int                  errors;
    int                  pending;
    int                  checked;
    int                  sent        = 0;
    int                  burst_left  = 0;
    int                  stall_phase = 0;

    // Per stream, the block of sequence numbers being sent in shuffled order.
    logic [SEQ_W-1:0]    block_base [STREAMS];
    logic [SEQ_W-1:0]    block_end  [STREAMS];
    logic [SEQ_W-1:0]    block_todo [STREAMS][WINDOW];
    int                  todo_left  [STREAMS];

    per_stream_resequencer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_stream_index (i_stream_index),
        .i_seq_number   (i_seq_number),
        .i_payload      (i_payload),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_status       (o_status),
        .o_out_stream   (o_out_stream),
        .o_out_seq      (o_out_seq),
        .o_out_payload  (o_out_payload),
        .o_last         (o_last)
    );

    resequencer_order_checker order_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_stream_index (i_stream_index),
        .i_seq_number   (i_seq_number),
        .i_payload      (i_payload),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_kind         (o_kind),
        .i_status       (o_status),
        .i_out_stream   (o_out_stream),
        .i_out_seq      (o_out_seq),
        .i_out_payload  (o_out_payload),
        .i_last         (o_last),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // Clock with a period of 12.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // The receiver steps through four stall patterns in turn: none, light, heavy and periodic.
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        case (t_stall_mode'((stall_phase / 97) % 4))
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 99) < 30);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 99) < 75);
            default:     i_out_stall <= (stall_phase % 3 == 0);
        endcase
    end

    // Offers one message and holds it until the transfer; bursts end in a random gap.
    task automatic send_message(input logic [STREAM_W-1:0] strm,
                                input logic [SEQ_W-1:0]    seq,
                                input logic [OUT_W-1:0]    word);
        int gap;
        i_in_valid     <= 1'b1;
        i_stream_index <= strm;
        i_seq_number   <= seq;
        i_payload      <= word;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(0, 24);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Picks a message: mostly shuffled blocks within the window, plus repeats,
    // duplicates and messages beyond the window.
    task automatic send_random_message();
        logic [STREAM_W-1:0] strm;
        logic [SEQ_W-1:0]    seq;
        logic [SEQ_W-1:0]    swap;
        int                  pick;
        int                  k;
        int                  j;
        int                  r;
        strm = STREAM_W'($urandom_range(0, STREAMS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            if (todo_left[strm] == 0) begin
                k = ($urandom_range(0, 4) == 0) ? WINDOW : $urandom_range(1, WINDOW);
                block_base[strm] = block_end[strm];
                for (j = 0; j < k; j++)
                    block_todo[strm][j] = block_base[strm] + SEQ_W'(j);
                for (j = k - 1; j > 0; j--) begin
                    r = $urandom_range(0, j);
                    swap                = block_todo[strm][j];
                    block_todo[strm][j] = block_todo[strm][r];
                    block_todo[strm][r] = swap;
                end
                block_end[strm] = block_base[strm] + SEQ_W'(k);
                todo_left[strm] = k;
            end
            todo_left[strm]--;
            seq = block_todo[strm][todo_left[strm]];
        end else if (pick < 85) begin
            // Repeat from the current block: buffered ones overwrite, released ones are late.
            if (block_end[strm] == block_base[strm])
                seq = block_base[strm] - 1'b1;
            else
                seq = block_base[strm]
                      + $urandom_range(0, block_end[strm] - block_base[strm] - 1);
        end else if (pick < 92) begin
            seq = $urandom_range(0, block_base[strm] - 1);
        end else if (pick < 96) begin
            seq = block_end[strm] + SEQ_W'(WINDOW + 1) + $urandom_range(0, 5000);
        end else begin
            seq = $urandom;
        end
        send_message(strm, seq, $urandom);
    endtask

    // Stimulus and verdict.
    initial begin
        int n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: duplicate, both window limits, extreme words and a full drain.
        send_message(2'd0, '0, '0);                   // below next-expected
        send_message(2'd0, SEQ_W'(17), $urandom);     // exactly one window ahead
        send_message(2'd3, '1, '1);                   // largest sequence number
        send_message(2'd1, SEQ_W'(1), '1);            // in order, released at once
        for (n = 16; n >= 2; n--)
            send_message(2'd0, SEQ_W'(n), $urandom);  // fills stream 0 up to the far edge
        send_message(2'd0, SEQ_W'(9), '0);            // repeat overwrites a buffered slot
        send_message(2'd0, SEQ_W'(1), 32'h5A5A_A5A5); // releases the whole window
        send_message(2'd0, SEQ_W'(16), $urandom);     // now a late duplicate

        // Shuffled blocks continue from where the directed part left each stream.
        block_base[0] = SEQ_W'(17);
        block_base[1] = SEQ_W'(2);
        block_base[2] = SEQ_W'(1);
        block_base[3] = SEQ_W'(1);
        for (n = 0; n < STREAMS; n++) begin
            block_end[n] = block_base[n];
            todo_left[n] = 0;
        end
        for (n = 0; n < RANDOM_MESSAGES; n++)
            send_random_message();
        i_in_valid <= 1'b0;

        // Wait for every predicted result, then let the block settle.
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d messages over %0d streams, including a full-window drain,",
                 sent, STREAMS);
        $display("duplicates, repeats and far-ahead numbers; %0d results compared, %0d errors.",
                 checked, errors);
        if (errors == 0)
            $display("** per_stream_resequencer: PASSED **");
        else
            $display("** per_stream_resequencer: FAILED **");
        $finish;
    end

    // Watchdog for a hung handshake or results that never arrive.
    initial begin
        #(12 * LIMIT_CYCLES);
        $display("Timed out waiting for transfers.");
        $display("** per_stream_resequencer: FAILED **");
        $finish;
    end

endmodule

// ===== per_stream_resequencer.f =====
+incdir+src
src/rsq_pkg.sv
src/rsq_state_mem.sv
src/rsq_slot_mem.sv
src/rsq_ctrl.sv
src/per_stream_resequencer.sv
tb/sv/resequencer_order_checker.sv
tb/sv/per_stream_resequencer_test.sv
